@@ design/plii_pkg.sv @@
// plii_pkg: shared constants, codes and the incidence plan table for the
// periodic lattice incidence index block
// no dependencies
package plii_pkg;

  localparam int ELEM_W       = 19;
  localparam int CFG_W        = 6;
  localparam int MAX_SIDE_DEF = 32;
  localparam int MIN_SIDE     = 2;
  localparam int MAX_RESULTS  = 6;
  localparam int CNT_W        = 3;
  localparam int SRC_COUNT    = 7;
  localparam int DIV3_SHIFT   = 20;

  localparam logic [CFG_W-1:0]  CFG_RESET  = 6'd4;
  localparam logic [ELEM_W-1:0] DIV3_RECIP = 19'd349526;
  localparam logic [2:0]        CFG_SETTLE = 3'd6;

  typedef enum logic [1:0] {
    OP_FACE_EDGES    = 2'd0,
    OP_EDGE_FACES    = 2'd1,
    OP_VERTEX_EDGES  = 2'd2,
    OP_EDGE_VERTICES = 2'd3
  } op_t;

  // which vertex a result is built from
  typedef enum logic [2:0] {
    SRC_V  = 3'd0,
    SRC_XP = 3'd1,
    SRC_XM = 3'd2,
    SRC_YP = 3'd3,
    SRC_YM = 3'd4,
    SRC_ZP = 3'd5,
    SRC_ZM = 3'd6
  } src_t;

  typedef struct packed {
    src_t       src;
    logic [1:0] off;
  } tap_t;

  typedef struct packed {
    logic [CNT_W-1:0]            cnt;
    logic                        mul3;
    tap_t [MAX_RESULTS-1:0]      tap;
  } plan_t;

  function automatic tap_t mk_tap(src_t s, logic [1:0] o);
    tap_t t;
    t.src = s;
    t.off = o;
    return t;
  endfunction

  function automatic plan_t incidence_plan(op_t op, logic [1:0] d);
    plan_t p;
    p = '0;
    p.mul3 = 1'b1;
    case (op)
      OP_FACE_EDGES: begin
        p.cnt = 3'd4;
        case (d)
          2'd0: begin
            p.tap[0] = mk_tap(SRC_V, 2'd0);
            p.tap[1] = mk_tap(SRC_V, 2'd1);
            p.tap[2] = mk_tap(SRC_XP, 2'd1);
            p.tap[3] = mk_tap(SRC_YP, 2'd0);
          end
          2'd1: begin
            p.tap[0] = mk_tap(SRC_V, 2'd0);
            p.tap[1] = mk_tap(SRC_V, 2'd2);
            p.tap[2] = mk_tap(SRC_XP, 2'd2);
            p.tap[3] = mk_tap(SRC_ZP, 2'd0);
          end
          default: begin
            p.tap[0] = mk_tap(SRC_V, 2'd1);
            p.tap[1] = mk_tap(SRC_V, 2'd2);
            p.tap[2] = mk_tap(SRC_YP, 2'd2);
            p.tap[3] = mk_tap(SRC_ZP, 2'd1);
          end
        endcase
      end
      OP_EDGE_FACES: begin
        p.cnt = 3'd4;
        case (d)
          2'd0: begin
            p.tap[0] = mk_tap(SRC_V, 2'd0);
            p.tap[1] = mk_tap(SRC_V, 2'd1);
            p.tap[2] = mk_tap(SRC_YM, 2'd0);
            p.tap[3] = mk_tap(SRC_ZM, 2'd1);
          end
          2'd1: begin
            p.tap[0] = mk_tap(SRC_V, 2'd0);
            p.tap[1] = mk_tap(SRC_V, 2'd2);
            p.tap[2] = mk_tap(SRC_XM, 2'd0);
            p.tap[3] = mk_tap(SRC_ZM, 2'd2);
          end
          default: begin
            p.tap[0] = mk_tap(SRC_V, 2'd2);
            p.tap[1] = mk_tap(SRC_V, 2'd1);
            p.tap[2] = mk_tap(SRC_YM, 2'd2);
            p.tap[3] = mk_tap(SRC_XM, 2'd1);
          end
        endcase
      end
      OP_VERTEX_EDGES: begin
        p.cnt = 3'd6;
        p.tap[0] = mk_tap(SRC_V, 2'd0);
        p.tap[1] = mk_tap(SRC_V, 2'd1);
        p.tap[2] = mk_tap(SRC_V, 2'd2);
        p.tap[3] = mk_tap(SRC_XM, 2'd0);
        p.tap[4] = mk_tap(SRC_YM, 2'd1);
        p.tap[5] = mk_tap(SRC_ZM, 2'd2);
      end
      default: begin
        p.cnt  = 3'd2;
        p.mul3 = 1'b0;
        p.tap[0] = mk_tap(SRC_V, 2'd0);
        case (d)
          2'd0:    p.tap[1] = mk_tap(SRC_XP, 2'd0);
          2'd1:    p.tap[1] = mk_tap(SRC_YP, 2'd0);
          default: p.tap[1] = mk_tap(SRC_ZP, 2'd0);
        endcase
      end
    endcase
    return p;
  endfunction

endpackage

@@ design/periodic_lattice_incidence_index.sv @@
// periodic_lattice_incidence_index: incident edge, face or vertex indices
// on a periodic cubic lattice, one result per cycle while out_ready is high
// depends on plii_pkg
// path: input register, divide-by-three register, the two restoring dividers,
//   the neighbor register and the result serializer
// results per input word: 4, 6, 2 or 1 (faces/edges, vertex
//   edges, edge vertices, flagged); a busy serializer stalls the pipeline
// reset: clears valid bits and the serializer, side_length returns to 4;
//   in_ready is held low after reset and each config write until hold is zero
module periodic_lattice_incidence_index #(
  parameter int MAX_SIDE = plii_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [plii_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [plii_pkg::ELEM_W-1:0]   element_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [plii_pkg::ELEM_W-1:0]   neighbor_index,
  output logic                          last,
  output logic                          out_of_range
);

  localparam int EW    = plii_pkg::ELEM_W;
  localparam int VW    = plii_pkg::ELEM_W;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int LLW   = 2 * SW;
  localparam int QAW   = $clog2(5 * MAX_SIDE * MAX_SIDE);
  localparam int ZW    = $clog2(5 * MAX_SIDE);
  localparam int RAW   = (VW > SW + QAW) ? VW : SW + QAW;
  localparam int RBW   = (QAW > SW + ZW) ? QAW : SW + ZW;
  localparam int NVW   = $clog2(5 * MAX_SIDE * MAX_SIDE * MAX_SIDE + 1);
  localparam int LIMW  = $clog2(15 * MAX_SIDE * MAX_SIDE * MAX_SIDE + 1);
  localparam int CMPW  = (LIMW > EW) ? LIMW : EW;
  localparam int NW    = (VW > NVW) ? VW : NVW;
  localparam int NR    = plii_pkg::MAX_RESULTS;
  localparam int CW    = plii_pkg::CNT_W;

  typedef struct packed {
    logic [1:0]     op;
    logic [1:0]     d;
    logic           oor;
    logic [VW-1:0]  v;
    logic [RAW-1:0] rem;
    logic [QAW-1:0] q;
  } a_stage_t;

  typedef struct packed {
    logic [1:0]     op;
    logic [1:0]     d;
    logic           oor;
    logic [VW-1:0]  v;
    logic [SW-1:0]  x;
    logic [RBW-1:0] rem;
    logic [ZW-1:0]  q;
  } b_stage_t;

  typedef struct packed {
    logic [1:0]                               op;
    logic [1:0]                               d;
    logic                                     oor;
    logic [plii_pkg::SRC_COUNT-1:0][NW-1:0]   nb;
  } n_stage_t;

  // configuration and derived lattice sizes
  logic [plii_pkg::CFG_W-1:0] side_length;
  logic [2:0]                 hold;
  logic [plii_pkg::CFG_W:0]   side_ext;
  logic [SW-1:0]              l_clamp;
  logic [SW-1:0]              l_eff;
  logic [SW-1:0]              lm1;
  logic [LLW-1:0]             ll;
  logic [LLW-1:0]             llml;
  logic [3*SW-1:0]            lll;
  logic [ZW-1:0]              z5m1;
  logic [NVW-1:0]             nv;
  logic [NVW-1:0]             nvmll;
  logic [LIMW-1:0]            nv3;

  logic adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= plii_pkg::CFG_RESET;
      hold        <= plii_pkg::CFG_SETTLE;
    end else if (cfg_valid && cfg_ready) begin
      side_length <= cfg_data;
      hold        <= plii_pkg::CFG_SETTLE;
    end else if (hold != 3'd0) begin
      hold <= hold - 3'd1;
    end
  end

  always_comb begin
    side_ext = {1'b0, side_length};
    if (side_ext < (plii_pkg::CFG_W+1)'(plii_pkg::MIN_SIDE)) begin
      l_clamp = SW'(plii_pkg::MIN_SIDE);
    end else if (side_ext > (plii_pkg::CFG_W+1)'(MAX_SIDE)) begin
      l_clamp = SW'(MAX_SIDE);
    end else begin
      l_clamp = SW'(side_ext);
    end
  end

  always_ff @(posedge clk) begin
    l_eff <= l_clamp;
    ll    <= LLW'(l_eff * l_eff);
    lm1   <= l_eff - SW'(1);
    z5m1  <= ZW'(((SW+3)'(l_eff) << 2) + (SW+3)'(l_eff) - (SW+3)'(1));
    lll   <= (3*SW)'(ll * l_eff);
    llml  <= ll - LLW'(l_eff);
    nv    <= NVW'(((3*SW+3)'(lll) << 2) + (3*SW+3)'(lll));
    nvmll <= nv - NVW'(ll);
    nv3   <= (LIMW'(nv) << 1) + LIMW'(nv);
  end

  // input stage
  logic           s0_vld;
  logic [1:0]     s0_op;
  logic [EW-1:0]  s0_e;
  logic           s0_oor;
  logic [CMPW-1:0] limit;

  assign in_ready = (hold == 3'd0) && adv;

  always_comb begin
    if (opcode == plii_pkg::OP_VERTEX_EDGES) begin
      limit = CMPW'(nv);
    end else begin
      limit = CMPW'(nv3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_op  <= opcode;
      s0_e   <= element_index;
      s0_oor <= CMPW'(element_index) >= limit;
    end
  end

  // divide by three through the reciprocal
  logic              s1_vld;
  logic [1:0]        s1_op;
  logic [EW-1:0]     s1_e;
  logic              s1_oor;
  logic [2*EW-1:0]   s1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op   <= s0_op;
      s1_e    <= s0_e;
      s1_oor  <= s0_oor;
      s1_prod <= s0_e * plii_pkg::DIV3_RECIP;
    end
  end

  // v mod L and v / L, one quotient bit a stage
  a_stage_t a_pipe [QAW+1];
  logic     a_vld  [QAW+1];
  a_stage_t a0_next;
  logic [VW-1:0] v_div;
  logic [VW-1:0] d_tmp;

  always_comb begin
    v_div = VW'(s1_prod >> plii_pkg::DIV3_SHIFT);
    d_tmp = s1_e - VW'({v_div, 1'b0}) - v_div;
    a0_next.op  = s1_op;
    a0_next.d   = d_tmp[1:0];
    a0_next.oor = s1_oor;
    if (s1_op == plii_pkg::OP_VERTEX_EDGES) begin
      a0_next.v = s1_e;
    end else begin
      a0_next.v = v_div;
    end
    a0_next.rem = RAW'(a0_next.v);
    a0_next.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld[0] <= 1'b0;
    end else if (adv) begin
      a_vld[0] <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pipe[0] <= a0_next;
    end
  end

  for (genvar j = 0; j < QAW; j++) begin : g_div_a
    localparam int BIT = QAW - 1 - j;
    logic [RAW-1:0] trial;
    a_stage_t       a_next;

    always_comb begin
      trial  = RAW'(l_eff) << BIT;
      a_next = a_pipe[j];
      if (a_pipe[j].rem >= trial) begin
        a_next.rem    = a_pipe[j].rem - trial;
        a_next.q[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_vld[j+1] <= 1'b0;
      end else if (adv) begin
        a_vld[j+1] <= a_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_pipe[j+1] <= a_next;
      end
    end
  end

  // (v / L) mod L and v / L^2
  b_stage_t b_pipe [ZW+1];
  logic     b_vld  [ZW+1];
  b_stage_t b0_next;

  always_comb begin
    b0_next.op  = a_pipe[QAW].op;
    b0_next.d   = a_pipe[QAW].d;
    b0_next.oor = a_pipe[QAW].oor;
    b0_next.v   = a_pipe[QAW].v;
    b0_next.x   = a_pipe[QAW].rem[SW-1:0];
    b0_next.rem = RBW'(a_pipe[QAW].q);
    b0_next.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld[0] <= 1'b0;
    end else if (adv) begin
      b_vld[0] <= a_vld[QAW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_pipe[0] <= b0_next;
    end
  end

  for (genvar j = 0; j < ZW; j++) begin : g_div_b
    localparam int BIT = ZW - 1 - j;
    logic [RBW-1:0] trial;
    b_stage_t       b_next;

    always_comb begin
      trial  = RBW'(l_eff) << BIT;
      b_next = b_pipe[j];
      if (b_pipe[j].rem >= trial) begin
        b_next.rem    = b_pipe[j].rem - trial;
        b_next.q[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        b_vld[j+1] <= 1'b0;
      end else if (adv) begin
        b_vld[j+1] <= b_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        b_pipe[j+1] <= b_next;
      end
    end
  end

  // neighbor vertices with wrap
  n_stage_t      n_stage;
  n_stage_t      n_next;
  logic          n_vld;
  logic [NW-1:0] vv;
  logic [SW-1:0] cx;
  logic [SW-1:0] cy;
  logic [ZW-1:0] cz;

  always_comb begin
    vv = NW'(b_pipe[ZW].v);
    cx = b_pipe[ZW].x;
    cy = b_pipe[ZW].rem[SW-1:0];
    cz = b_pipe[ZW].q;
    n_next.op  = b_pipe[ZW].op;
    n_next.d   = b_pipe[ZW].d;
    n_next.oor = b_pipe[ZW].oor;
    n_next.nb  = '0;
    n_next.nb[plii_pkg::SRC_V] = vv;
    n_next.nb[plii_pkg::SRC_XP] = (cx == lm1) ? vv - NW'(lm1) : vv + NW'(1);
    n_next.nb[plii_pkg::SRC_XM] = (cx == '0) ? vv + NW'(lm1) : vv - NW'(1);
    n_next.nb[plii_pkg::SRC_YP] = (cy == lm1) ? vv - NW'(llml) : vv + NW'(l_eff);
    n_next.nb[plii_pkg::SRC_YM] = (cy == '0) ? vv + NW'(llml) : vv - NW'(l_eff);
    n_next.nb[plii_pkg::SRC_ZP] = (cz == z5m1) ? vv - NW'(nvmll) : vv + NW'(ll);
    n_next.nb[plii_pkg::SRC_ZM] = (cz == '0) ? vv + NW'(nvmll) : vv - NW'(ll);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else if (adv) begin
      n_vld <= b_vld[ZW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_stage <= n_next;
    end
  end

  // result serializer, doubles as the output register
  logic [EW-1:0]   sr [NR];
  logic [EW-1:0]   sr_next [NR];
  logic [CW-1:0]   ser_cnt;
  logic [CW-1:0]   cnt_next;
  logic            ser_oor;
  logic            ser_free;
  logic            ser_load;
  logic            out_take;
  plii_pkg::plan_t plan;

  always_comb begin
    logic [NW-1:0]  nsel;
    logic [NW+1:0]  t;
    logic [NW+1:0]  val;
    plan = plii_pkg::incidence_plan(plii_pkg::op_t'(n_stage.op), n_stage.d);
    for (int k = 0; k < NR; k++) begin
      nsel = n_stage.nb[plan.tap[k].src];
      t    = (NW+2)'(nsel);
      if (plan.mul3) begin
        val = (t << 1) + t + (NW+2)'(plan.tap[k].off);
      end else begin
        val = t;
      end
      sr_next[k] = val[EW-1:0];
    end
    cnt_next = plan.cnt;
    if (n_stage.oor) begin
      sr_next[0] = '0;
      cnt_next   = CW'(1);
    end
  end

  assign out_take = out_valid && out_ready;
  assign ser_free = (ser_cnt == '0) || (out_ready && ser_cnt == CW'(1));
  assign ser_load = n_vld && ser_free;
  assign adv      = !n_vld || ser_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_cnt <= '0;
    end else if (ser_load) begin
      ser_cnt <= cnt_next;
    end else if (out_take) begin
      ser_cnt <= ser_cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_oor <= n_stage.oor;
      for (int k = 0; k < NR; k++) begin
        sr[k] <= sr_next[k];
      end
    end else if (out_take) begin
      for (int k = 0; k < NR - 1; k++) begin
        sr[k] <= sr[k+1];
      end
    end
  end

  assign out_valid      = ser_cnt != '0;
  assign neighbor_index = sr[0];
  assign last           = ser_cnt == CW'(1);
  assign out_of_range   = ser_oor;

endmodule

@@ tb/tb_periodic_lattice_incidence_index.sv @@
// tb_periodic_lattice_incidence_index: self-checking bench for the lattice incidence block,
// predicts every result word, compares in order; random gaps and stalls in most phases
// depends on plii_pkg and periodic_lattice_incidence_index
module tb_periodic_lattice_incidence_index;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ELEM_W       = plii_pkg::ELEM_W;
  localparam int CFG_W        = plii_pkg::CFG_W;
  localparam int MIN_SIDE     = plii_pkg::MIN_SIDE;
  localparam int MAX_SIDE_DEF = plii_pkg::MAX_SIDE_DEF;

  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int DRAIN_CYCLES     = 60;
  localparam int RANDOM_PER_PHASE = 42;

  typedef struct {
    plii_pkg::op_t     op;
    logic [ELEM_W-1:0] idx;
  } query_t;

  typedef struct {
    logic [ELEM_W-1:0] nbr;
    logic              last;
    logic              oor;
  } incidence_t;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              cfg_valid     = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data      = '0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [1:0]        opcode        = '0;
  logic [ELEM_W-1:0] element_index = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [ELEM_W-1:0] neighbor_index;
  logic              last;
  logic              out_of_range;

  query_t           pending_queries[$];
  incidence_t       incidence_queue[$];
  logic [CFG_W-1:0] side_reg      = plii_pkg::CFG_RESET;
  int               fail_count    = 0;
  int               idle_cycles   = 0;
  int               in_gap        = 0;
  int               out_stall     = 0;
  bit               in_gaps_on    = 1'b1;
  bit               out_stalls_on = 1'b1;

  periodic_lattice_incidence_index #(
    .MAX_SIDE(MAX_SIDE_DEF)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .element_index (element_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .neighbor_index(neighbor_index),
    .last          (last),
    .out_of_range  (out_of_range)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned effective_side(logic [CFG_W-1:0] s);
    int unsigned l;
    l = s;
    if (l < MIN_SIDE) l = MIN_SIDE;
    if (l > MAX_SIDE_DEF) l = MAX_SIDE_DEF;
    return l;
  endfunction

  function automatic int unsigned element_count(plii_pkg::op_t op, int unsigned l);
    int unsigned nv;
    nv = 5 * l * l * l;
    return (op == plii_pkg::OP_VERTEX_EDGES) ? nv : 3 * nv;
  endfunction

  function automatic int unsigned lattice_step(int unsigned v, int unsigned axis, bit up,
                                               int unsigned l);
    int unsigned x, y, z, zl;
    zl = 5 * l;
    x = v % l;
    y = (v / l) % l;
    z = (v / (l * l)) % zl;
    case (axis)
      0: x = up ? (x + 1) % l : (x + l - 1) % l;
      1: y = up ? (y + 1) % l : (y + l - 1) % l;
      default: z = up ? (z + 1) % zl : (z + zl - 1) % zl;
    endcase
    return x + y * l + z * l * l;
  endfunction

  task automatic expect_word(incidence_t w);
    incidence_queue.insert(incidence_queue.size(), w);
  endtask

  task automatic queue_query(query_t q);
    pending_queries.insert(pending_queries.size(), q);
  endtask

  task automatic push_incidences(query_t q);
    int unsigned l, v, d, n;
    int unsigned r[6];
    incidence_t w;
    l = effective_side(side_reg);
    n = 0;
    v = q.idx / 3;
    d = q.idx % 3;
    if (q.idx >= element_count(q.op, l)) begin
      w.nbr  = '0;
      w.last = 1'b1;
      w.oor  = 1'b1;
      expect_word(w);
    end else begin
      case (q.op)
        plii_pkg::OP_FACE_EDGES: begin
          n = 4;
          case (d)
            0: begin
              r[0] = 3 * v;
              r[1] = 3 * v + 1;
              r[2] = 3 * lattice_step(v, 0, 1'b1, l) + 1;
              r[3] = 3 * lattice_step(v, 1, 1'b1, l);
            end
            1: begin
              r[0] = 3 * v;
              r[1] = 3 * v + 2;
              r[2] = 3 * lattice_step(v, 0, 1'b1, l) + 2;
              r[3] = 3 * lattice_step(v, 2, 1'b1, l);
            end
            default: begin
              r[0] = 3 * v + 1;
              r[1] = 3 * v + 2;
              r[2] = 3 * lattice_step(v, 1, 1'b1, l) + 2;
              r[3] = 3 * lattice_step(v, 2, 1'b1, l) + 1;
            end
          endcase
        end
        plii_pkg::OP_EDGE_FACES: begin
          n = 4;
          case (d)
            0: begin
              r[0] = 3 * v;
              r[1] = 3 * v + 1;
              r[2] = 3 * lattice_step(v, 1, 1'b0, l);
              r[3] = 3 * lattice_step(v, 2, 1'b0, l) + 1;
            end
            1: begin
              r[0] = 3 * v;
              r[1] = 3 * v + 2;
              r[2] = 3 * lattice_step(v, 0, 1'b0, l);
              r[3] = 3 * lattice_step(v, 2, 1'b0, l) + 2;
            end
            default: begin
              r[0] = 3 * v + 2;
              r[1] = 3 * v + 1;
              r[2] = 3 * lattice_step(v, 1, 1'b0, l) + 2;
              r[3] = 3 * lattice_step(v, 0, 1'b0, l) + 1;
            end
          endcase
        end
        plii_pkg::OP_VERTEX_EDGES: begin
          n = 6;
          v = q.idx;
          r[0] = 3 * v;
          r[1] = 3 * v + 1;
          r[2] = 3 * v + 2;
          r[3] = 3 * lattice_step(v, 0, 1'b0, l);
          r[4] = 3 * lattice_step(v, 1, 1'b0, l) + 1;
          r[5] = 3 * lattice_step(v, 2, 1'b0, l) + 2;
        end
        default: begin
          n = 2;
          r[0] = v;
          r[1] = lattice_step(v, d, 1'b1, l);
        end
      endcase
      for (int k = 0; k < n; k++) begin
        w.nbr  = ELEM_W'(r[k]);
        w.last = (k == n - 1);
        w.oor  = 1'b0;
        expect_word(w);
      end
    end
  endtask

  function automatic query_t mk_query(plii_pkg::op_t op, int unsigned idx);
    query_t q;
    q.op  = op;
    q.idx = ELEM_W'(idx);
    return q;
  endfunction

  // mostly on a wrapping face of the box
  function automatic int unsigned edge_coord(int unsigned n);
    case ($urandom_range(0, 2))
      0: return 0;
      1: return n - 1;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  function automatic query_t random_query(int unsigned l);
    query_t q;
    int unsigned cnt, v, r;
    q.op = plii_pkg::op_t'($urandom_range(0, 3));
    cnt  = element_count(q.op, l);
    r    = $urandom_range(0, 99);
    if (r < 68) begin
      q.idx = ELEM_W'($urandom_range(0, cnt - 1));
    end else if (r < 85) begin
      v = edge_coord(l) + edge_coord(l) * l + edge_coord(5 * l) * l * l;
      q.idx = (q.op == plii_pkg::OP_VERTEX_EDGES) ? ELEM_W'(v)
                                                  : ELEM_W'(3 * v + $urandom_range(0, 2));
    end else if (r < 93) begin
      q.idx = ELEM_W'(cnt - 1 + $urandom_range(0, 1));
    end else begin
      q.idx = ELEM_W'($urandom);
    end
    return q;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // driver
  always @(posedge clk) begin
    query_t q;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        q.op  = plii_pkg::op_t'(opcode);
        q.idx = element_index;
        push_incidences(q);
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pending_queries.size() > 0) begin
          q = pending_queries.pop_front();
          in_valid      <= 1'b1;
          opcode        <= q.op;
          element_index <= q.idx;
          in_gap        <= in_gaps_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    incidence_t w;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (incidence_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected word index %0d last %0b flag %0b",
                                    neighbor_index, last, out_of_range));
        end else begin
          w = incidence_queue.pop_front();
          if (neighbor_index !== w.nbr)
            report_mismatch($sformatf("neighbor_index %0d, want %0d", neighbor_index, w.nbr));
          if (last !== w.last)
            report_mismatch($sformatf("last %0b, want %0b", last, w.last));
          if (out_of_range !== w.oor)
            report_mismatch($sformatf("out_of_range %0b, want %0b", out_of_range, w.oor));
        end
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_stalls_on && $urandom_range(0, 3) == 0) out_stall <= pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CFG_W-1:0] side_plan[$];
    int unsigned l, nv, ne;
    side_plan = '{6'd2, 6'd0, 6'd32, 6'd63, 6'd1, 6'd3, 6'd33, 6'd17, 6'd4, 6'd9};
    side_plan.insert(side_plan.size(), CFG_W'($urandom_range(MIN_SIDE, MAX_SIDE_DEF)));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // corners and limits at the reset side
    @(negedge clk);
    l  = effective_side(side_reg);
    nv = element_count(plii_pkg::OP_VERTEX_EDGES, l);
    ne = element_count(plii_pkg::OP_FACE_EDGES, l);
    queue_query(mk_query(plii_pkg::OP_FACE_EDGES, 0));
    queue_query(mk_query(plii_pkg::OP_FACE_EDGES, 1));
    queue_query(mk_query(plii_pkg::OP_FACE_EDGES, 2));
    queue_query(mk_query(plii_pkg::OP_FACE_EDGES, ne - 1));
    queue_query(mk_query(plii_pkg::OP_FACE_EDGES, ne));
    queue_query(mk_query(plii_pkg::OP_FACE_EDGES, (1 << ELEM_W) - 1));
    queue_query(mk_query(plii_pkg::OP_EDGE_FACES, 0));
    queue_query(mk_query(plii_pkg::OP_EDGE_FACES, 1));
    queue_query(mk_query(plii_pkg::OP_EDGE_FACES, 2));
    queue_query(mk_query(plii_pkg::OP_EDGE_FACES, ne - 1));
    queue_query(mk_query(plii_pkg::OP_EDGE_FACES, ne));
    queue_query(mk_query(plii_pkg::OP_VERTEX_EDGES, 0));
    queue_query(mk_query(plii_pkg::OP_VERTEX_EDGES, nv - 1));
    queue_query(mk_query(plii_pkg::OP_VERTEX_EDGES, nv));
    queue_query(mk_query(plii_pkg::OP_VERTEX_EDGES, (1 << ELEM_W) - 1));
    queue_query(mk_query(plii_pkg::OP_EDGE_VERTICES, 0));
    queue_query(mk_query(plii_pkg::OP_EDGE_VERTICES, ne - 3));
    queue_query(mk_query(plii_pkg::OP_EDGE_VERTICES, ne - 2));
    queue_query(mk_query(plii_pkg::OP_EDGE_VERTICES, ne - 1));
    queue_query(mk_query(plii_pkg::OP_EDGE_VERTICES, ne));
    repeat (RANDOM_PER_PHASE) queue_query(random_query(l));

    for (int p = 0; p < side_plan.size(); p++) begin
      do @(negedge clk);
      while (pending_queries.size() != 0 || in_valid || incidence_queue.size() != 0);

      @(posedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= side_plan[p];
      do @(posedge clk);
      while (!cfg_ready);
      cfg_valid <= 1'b0;
      side_reg = side_plan[p];

      @(negedge clk);
      in_gaps_on    = (p % 4 != 2);
      out_stalls_on = (p % 4 != 2) && (p % 5 != 3);
      l = effective_side(side_reg);
      repeat (RANDOM_PER_PHASE) queue_query(random_query(l));
    end

    do @(negedge clk);
    while (pending_queries.size() != 0 || in_valid || incidence_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
